/* rtl/core/delay_aware_round_robin_scheduler_top_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Included by delay_aware_round_robin_scheduler_top.sv; relies on aclk and aresetn in scope.
`ifndef DELAY_AWARE_ROUND_ROBIN_SCHEDULER_TOP_MACROS_SVH
`define DELAY_AWARE_ROUND_ROBIN_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DARS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DARS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

/* rtl/core/dars_pkg.sv */
// Shared types and constants of the delay-aware round-robin scheduler.
// No dependencies; imported by dars_cell and the top level.
package dars_pkg;

    localparam int TASKS_DEFAULT      = 4;
    localparam int DELAY_BITS_DEFAULT = 32;

    localparam int ACTION_W = 2;
    localparam int TASK_W   = 2;
    localparam int TICKS_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELAY   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

    // Command broadcast from the top level to every task cell.
    typedef struct packed {
        logic               tick;
        logic               delay;
        logic               release_all;
        logic [TASK_W-1:0]  cur_task;
        logic [TICKS_W-1:0] ticks;
    } cmd_t;

endpackage

/* rtl/core/dars_cell.sv */
// One task cell: delay counter, ready bit and one stage of the rank ripple.
// Depends on dars_pkg.
module dars_cell #(
    parameter int TASKS      = 4,
    parameter int DELAY_BITS = 32,
    parameter int INDEX      = 0,
    parameter int IW         = $clog2(TASKS),
    parameter int CW         = $clog2(TASKS + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  dars_pkg::cmd_t cmd,
    input  logic [CW-1:0]  rr_pos,
    input  logic [CW-1:0]  rr_pos_inc,
    input  logic           link_valid_in,
    input  logic [CW-1:0]  link_count_in,
    input  logic [IW-1:0]  link_first_in,
    input  logic [IW-1:0]  link_at_pos_in,
    input  logic [IW-1:0]  link_after_pos_in,
    output logic           link_valid_out,
    output logic [CW-1:0]  link_count_out,
    output logic [IW-1:0]  link_first_out,
    output logic [IW-1:0]  link_at_pos_out,
    output logic [IW-1:0]  link_after_pos_out
);
    import dars_pkg::*;

    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [DELAY_BITS-1:0] cnt_reg, cnt_next;
    logic                  ready_reg, ready_next;
    logic                  valid_reg;
    logic [CW-1:0]         count_reg;
    logic [IW-1:0]         first_reg, at_pos_reg, after_pos_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        ready_next = ready_reg;
        if (cmd.tick) begin
            if (cnt_reg != '0) begin
                cnt_next = cnt_reg - DELAY_BITS'(1);
            end
            if (cnt_next == '0) begin
                ready_next = 1'b1;
            end
        end else if (cmd.delay && (int'(cmd.cur_task) == INDEX)) begin
            ready_next = 1'b0;
            cnt_next   = cmd.ticks[DELAY_BITS-1:0];
        end else if (cmd.release_all) begin
            ready_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
            valid_reg <= link_valid_in;
        end
    end

    // Rank stage: a ready task takes the rank counted so far and bumps the count.
    always_ff @(posedge aclk) begin
        count_reg     <= link_count_in + CW'(ready_reg);
        first_reg     <= (ready_reg && link_count_in == '0) ? MY_INDEX : link_first_in;
        at_pos_reg    <= (ready_reg && link_count_in == rr_pos) ? MY_INDEX : link_at_pos_in;
        after_pos_reg <= (ready_reg && link_count_in == rr_pos_inc) ? MY_INDEX
                                                                     : link_after_pos_in;
    end

    assign link_valid_out     = valid_reg;
    assign link_count_out     = count_reg;
    assign link_first_out     = first_reg;
    assign link_at_pos_out    = at_pos_reg;
    assign link_after_pos_out = after_pos_reg;

endmodule

/* rtl/core/delay_aware_round_robin_scheduler_top.sv */
// Top level of the delay-aware round-robin task scheduler.
// Depends on dars_pkg, dars_cell and delay_aware_round_robin_scheduler_top_macros.svh.
//
// This block keeps a delay counter and a ready bit for each of TASKS tasks and
// picks the task to run next. A request on the input stream carries an action in
// s_tuser: a tick, a delay request for the current task, or a release of all
// waiting tasks. Every request returns exactly one result on the output stream:
// the next task, a switch request flag and a sticky idle flag. Delay and release
// requests return the unchanged choice. A tick updates all counters at once and
// then ripples a rank count through a chain of task cells, one cell per cycle,
// which yields the compact ready list entries the round-robin scan needs; no new
// request is taken while the wave is still in the chain. The output is held in a
// register, and a new request is taken only while that register is empty or in
// the cycle that its result leaves on m_tready.
module delay_aware_round_robin_scheduler_top #(
    parameter int TASKS      = dars_pkg::TASKS_DEFAULT,
    parameter int DELAY_BITS = dars_pkg::DELAY_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: current_task[1:0], delay_ticks[33:2],
    // delay_pending[34], zero fill [39:35].
    input  logic [39:0] s_tdata,
    // s_tuser, lowest bit up: action[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: run_task[1:0], switch_request[2], idle[3],
    // zero fill [7:4].
    output logic [7:0]  m_tdata
);
    import dars_pkg::*;

    localparam int IW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic          state_reg, state_next;
    logic          start_reg;
    logic [IW-1:0] rr_reg, rr_next;
    logic [IW-1:0] chosen_reg, chosen_next;
    logic          idle_seen_reg, idle_seen_next;
    logic [1:0]    cur_hold_reg;
    logic          hold_reg;
    logic          m_valid_reg;
    logic [3:0]    m_data_reg;

    logic           accept;
    logic [1:0]     in_action;
    cmd_t           cmd;
    logic [CW-1:0]  rr_ext, rr_inc;
    logic [IW+1:0]  chosen_wide;
    logic [1:0]     run_task_lo;

    logic [TASKS:0] lv;
    logic [CW-1:0]  lc [TASKS+1];
    logic [IW-1:0]  lf [TASKS+1];
    logic [IW-1:0]  lp [TASKS+1];
    logic [IW-1:0]  la [TASKS+1];

    // Input side is open only between ticks and while the result slot is free
    // or being emptied in this cycle.
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign in_action = s_tuser;

    always_comb begin
        cmd.tick        = accept && (in_action == ACT_TICK);
        cmd.delay       = accept && (in_action == ACT_DELAY);
        cmd.release_all = accept && (in_action == ACT_RELEASE);
        cmd.cur_task    = s_tdata[1:0];
        cmd.ticks       = s_tdata[33:2];
    end

    assign rr_ext = CW'(rr_reg);
    assign rr_inc = rr_ext + CW'(1);

    // The rank wave enters the first cell empty in the cycle after the tick.
    assign lv[0] = start_reg;
    assign lc[0] = '0;
    assign lf[0] = '0;
    assign lp[0] = '0;
    assign la[0] = '0;

    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        dars_cell #(
            .TASKS      (TASKS),
            .DELAY_BITS (DELAY_BITS),
            .INDEX      (g),
            .IW         (IW),
            .CW         (CW)
        ) u_cell (
            .aclk               (aclk),
            .aresetn            (aresetn),
            .cmd                (cmd),
            .rr_pos             (rr_ext),
            .rr_pos_inc         (rr_inc),
            .link_valid_in      (lv[g]),
            .link_count_in      (lc[g]),
            .link_first_in      (lf[g]),
            .link_at_pos_in     (lp[g]),
            .link_after_pos_in  (la[g]),
            .link_valid_out     (lv[g+1]),
            .link_count_out     (lc[g+1]),
            .link_first_out     (lf[g+1]),
            .link_at_pos_out    (lp[g+1]),
            .link_after_pos_out (la[g+1])
        );
    end

    // Round-robin choice once the wave has left the last cell. The count it
    // carries is the number of ready tasks.
    always_comb begin
        rr_next        = rr_reg;
        chosen_next    = chosen_reg;
        idle_seen_next = idle_seen_reg;
        if (lv[TASKS]) begin
            if (lc[TASKS] == '0) begin
                idle_seen_next = 1'b1;
                chosen_next    = '0;
            end else if (rr_inc >= lc[TASKS]) begin
                rr_next     = '0;
                chosen_next = lf[TASKS];
            end else if (hold_reg) begin
                chosen_next = lp[TASKS];
            end else begin
                rr_next     = IW'(rr_inc);
                chosen_next = la[TASKS];
            end
        end
    end

    // Only the low two bits of the chosen index leave the block.
    assign chosen_wide = {2'b00, chosen_next};
    assign run_task_lo = chosen_wide[1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.tick) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (lv[TASKS]) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            rr_reg        <= '0;
            chosen_reg    <= IW'(1);
            idle_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_reg     <= cmd.tick;
            rr_reg        <= rr_next;
            chosen_reg    <= chosen_next;
            idle_seen_reg <= idle_seen_next;
            if (lv[TASKS] || (accept && !cmd.tick)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            cur_hold_reg <= s_tdata[1:0];
            hold_reg     <= s_tdata[34];
        end
        if (lv[TASKS]) begin
            m_data_reg <= {idle_seen_next, (run_task_lo != cur_hold_reg), run_task_lo};
        end else if (accept && !cmd.tick) begin
            m_data_reg <= {idle_seen_reg, 1'b0, run_task_lo};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

`include "delay_aware_round_robin_scheduler_top_macros.svh"

    // No request is taken while a tick is still rippling through the cells.
    `DARS_ASSERT_IMPLIES(a_ready_only_idle, s_tready, state_reg == ST_IDLE)
    // A tick launches exactly one rank wave and enters the scan state.
    `DARS_ASSERT_NEXT(a_tick_starts_wave, cmd.tick, start_reg && state_reg == ST_SCAN)
    // The wave finishes only while a tick is in flight.
    `DARS_ASSERT_IMPLIES(a_wave_in_scan, lv[TASKS], state_reg == ST_SCAN)
    // The idle flag never clears once set.
    `DARS_ASSERT_NEXT(a_idle_sticky, idle_seen_reg, idle_seen_reg)

endmodule
